FILE: design/fdce_pkg.sv
`timescale 1ns / 1ps

package fdce_pkg;

	// drive geometry
	localparam int CYLINDERS         = 80;
	localparam int SECTORS_PER_TRACK = 18;
	localparam int PARKED_CYLINDER   = 80;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [3:0] {
		OP_MOUNT   = 4'd0,
		OP_UNMOUNT = 4'd1,
		OP_RESET   = 4'd2,
		OP_START   = 4'd3,
		OP_STOP    = 4'd4,
		OP_CALIB   = 4'd5,
		OP_STATUS  = 4'd6,
		OP_SEEK    = 4'd7,
		OP_READ    = 4'd8,
		OP_WRITE   = 4'd9,
		OP_BAD     = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		MODE_EMPTY    = 2'd0,
		MODE_MOUNTED  = 2'd1,
		MODE_SPINNING = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_NOT_READY     = 3'd1,
		ST_BAD_PARAM     = 3'd2,
		ST_BAD_CYL       = 3'd3,
		ST_MOTOR_REFUSED = 3'd4,
		ST_MOUNT_FAILED  = 3'd5
	} status_t;

	// classified command as it travels from front to back
	typedef struct packed {
		op_t        op;
		logic       mount_ok;
		logic       target_ok;
		logic [7:0] target;
		logic       head;
		logic [4:0] first;
		logic [4:0] total;
		logic       xfer_ok;
	} cmd_item_t;

endpackage

FILE: design/floppy_drive_command_engine_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   command item, tdata 32 bits
// m_*       out        m_tvalid/m_tready   result item, tdata 40 bits
//
// one item per cycle sustained while m_tready stays high; an accepted item is
// registered in turn in the front register, the command queue and the result
// register, which drives m_tvalid; all drive state lives in the back end,
// which retires one command per cycle while m_tready stays high
// arst_n clears handshakes and drive state: not mounted, head parked
// the two-entry queue lets the front keep taking items while the result
// register waits on m_tready

module floppy_drive_command_engine_core import fdce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// command[3:0], mount_ok[4], target_cylinder[12:5], head_select[14:13],
	// first_sector[19:15], sector_total[24:20], zero pad[31:25]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status_code[2:0], status_byte[10:3], start_block[22:11],
	// transfer_sectors[27:23], drive_state[29:28], image_present[30],
	// seek_steps[37:31], zero pad[39:38]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// front to queue
	logic      fq_valid;
	logic      fq_ready;
	cmd_item_t fq_item;

	// queue to back
	logic      qb_valid;
	logic      qb_ready;
	cmd_item_t qb_item;

	// front: accept and classify, checks that need no drive state
	fdce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (fq_valid),
		.item_ready (fq_ready),
		.item       (fq_item)
	);

	// short command queue decoupling front from back
	fdce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_item  (fq_item),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_item  (qb_item)
	);

	// back: execute against drive state, register the result
	fdce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (qb_valid),
		.item_ready (qb_ready),
		.item       (qb_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// a transfer count only comes with an accepted read or write
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[27:23] != 5'd0) |->
			(m_tdata[2:0] == ST_OK) && (m_tdata[37:31] == 7'd0) &&
			(m_tdata[10:3] == 8'd0))
		else $error("transfer result carries foreign fields");

	// a seek distance only comes with an accepted seek
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[37:31] != 7'd0) |->
			(m_tdata[2:0] == ST_OK) && (m_tdata[29:28] == MODE_SPINNING))
		else $error("seek distance without accepted seek");

	// a status byte always has its top bit set, ok status and no block address
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10:3] != 8'd0) |->
			m_tdata[10] && (m_tdata[2:0] == ST_OK) && (m_tdata[22:11] == 12'd0))
		else $error("malformed status byte");

	// a mounted or spinning drive always holds an image
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[29:28] != MODE_EMPTY) |-> m_tdata[30])
		else $error("mounted state without image");

endmodule

FILE: design/fdce_front.sv
`timescale 1ns / 1ps

module fdce_front import fdce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	output logic                 item_valid,
	input  logic                 item_ready,
	output cmd_item_t            item
);

	logic      valid_s1;
	cmd_item_t item_s1;
	cmd_item_t cls;

	logic [3:0] cmd;
	logic [1:0] head;
	logic [4:0] first;
	logic [4:0] total;
	logic [5:0] span;

	assign cmd   = s_tdata[3:0];
	assign head  = s_tdata[14:13];
	assign first = s_tdata[19:15];
	assign total = s_tdata[24:20];
	assign span  = {1'b0, first} + {1'b0, total};

	// state-independent checks are done here
	always_comb begin
		cls.op        = (cmd <= OP_WRITE) ? op_t'(cmd) : OP_BAD;
		cls.mount_ok  = s_tdata[4];
		cls.target    = s_tdata[12:5];
		cls.target_ok = s_tdata[12:5] < 8'(CYLINDERS);
		cls.head      = head[0];
		cls.first     = first;
		cls.total     = total;
		cls.xfer_ok   = (head <= 2'd1) && (first < 5'(SECTORS_PER_TRACK)) &&
			(total != 5'd0) && (total <= 5'(SECTORS_PER_TRACK)) &&
			(span <= 6'(SECTORS_PER_TRACK));
	end

	assign s_tready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

FILE: design/fdce_queue.sv
`timescale 1ns / 1ps

module fdce_queue import fdce_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  cmd_item_t wr_item,
	output logic      rd_valid,
	input  logic      rd_ready,
	output cmd_item_t rd_item
);

	cmd_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_item  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

FILE: design/fdce_back.sv
`timescale 1ns / 1ps

module fdce_back import fdce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  cmd_item_t             item,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	mode_t      mode_q, mode_d;
	logic [6:0] cyl_q, cyl_d;
	logic       media_q, media_d;

	logic       m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	status_t    status;
	logic [7:0] status_byte;
	logic [11:0] start_block;
	logic [4:0] transfer;
	logic [6:0] seek_steps;
	logic [7:0] cyl_gap;
	logic [13:0] lba;
	logic       pop;

	assign pop        = item_valid && (!m_valid_q || m_tready);
	assign item_ready = !m_valid_q || m_tready;

	assign cyl_gap = (item.target > {1'b0, cyl_q}) ? item.target - {1'b0, cyl_q}
		: {1'b0, cyl_q} - item.target;
	assign lba = 14'({cyl_q, item.head}) * 14'(SECTORS_PER_TRACK) + 14'(item.first);

	// next state
	always_comb begin
		mode_d  = mode_q;
		cyl_d   = cyl_q;
		media_d = media_q;
		unique case (item.op)
			OP_MOUNT: begin
				if (item.mount_ok) begin
					media_d = 1'b1;
					mode_d  = MODE_MOUNTED;
				end else begin
					mode_d = MODE_EMPTY;
				end
			end
			OP_UNMOUNT: begin
				media_d = 1'b0;
				mode_d  = MODE_EMPTY;
			end
			OP_RESET, OP_STOP: begin
				if (mode_q == MODE_SPINNING) mode_d = MODE_MOUNTED;
			end
			OP_START: begin
				if (mode_q == MODE_MOUNTED) mode_d = MODE_SPINNING;
			end
			OP_CALIB: begin
				if (mode_q == MODE_SPINNING) cyl_d = 7'd0;
			end
			OP_SEEK: begin
				if (mode_q == MODE_SPINNING && item.target_ok) cyl_d = item.target[6:0];
			end
			default: begin
			end
		endcase
	end

	// result fields
	always_comb begin
		status      = ST_OK;
		status_byte = 8'd0;
		start_block = 12'd0;
		transfer    = 5'd0;
		seek_steps  = 7'd0;
		unique case (item.op)
			OP_MOUNT: begin
				if (!item.mount_ok) status = ST_MOUNT_FAILED;
			end
			OP_UNMOUNT, OP_RESET: begin
			end
			OP_START: begin
				if (mode_q != MODE_MOUNTED) status = ST_MOTOR_REFUSED;
			end
			OP_STOP: begin
				if (mode_q != MODE_SPINNING) status = ST_MOTOR_REFUSED;
			end
			OP_CALIB: begin
				if (mode_q != MODE_SPINNING) status = ST_NOT_READY;
			end
			OP_STATUS: begin
				status_byte = {1'b1, cyl_q};
			end
			OP_SEEK: begin
				if (mode_q != MODE_SPINNING) begin
					status = ST_NOT_READY;
				end else if (!item.target_ok) begin
					status = ST_BAD_PARAM;
				end else begin
					seek_steps = cyl_gap[6:0];
				end
			end
			OP_READ, OP_WRITE: begin
				if (mode_q != MODE_SPINNING) begin
					status = ST_NOT_READY;
				end else if (cyl_q == 7'(PARKED_CYLINDER)) begin
					status = ST_BAD_CYL;
				end else if (!item.xfer_ok) begin
					status = ST_BAD_PARAM;
				end else begin
					start_block = lba[11:0];
					transfer    = item.total;
				end
			end
			default: begin
				status = ST_BAD_PARAM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_EMPTY;
			cyl_q     <= 7'(PARKED_CYLINDER);
			media_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q  <= mode_d;
				cyl_q   <= cyl_d;
				media_q <= media_d;
			end
			if (item_ready) m_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_data_q <= {2'b00, seek_steps, media_d, mode_d, transfer, start_block,
				status_byte, status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
